// File: rtl/sbps_pkg.sv
// Package for the streaming byte pattern search block.
// Holds the shared widths, register indexes, record codes and the result type.
// No dependencies.
package sbps_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OFF_OUT_W  = 32;
  // Wide enough for pattern lengths and fill counts up to 64.
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_LEN_W  = 5;
  localparam int unsigned REG_BYTES  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP     = 2'd3;

  localparam logic REC_MATCH = 1'b0;
  localparam logic REC_DONE  = 1'b1;

  // Records produced by one input byte: an optional match, then an optional done.
  typedef struct packed {
    logic                 has_match;
    logic [OFF_OUT_W-1:0] offset;
    logic                 has_done;
    logic                 found;
  } sbps_res_t;

endpackage

// File: rtl/sbps_if.sv
// Valid/ready channel interfaces for the streaming byte pattern search block.
// Input channel carries file bytes, output channel carries result records.
// Depends on sbps_pkg.
interface sbps_in_if;
  import sbps_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_file;

  modport source(output valid, data_byte, end_of_file, input ready);
  modport sink(input valid, data_byte, end_of_file, output ready);
endinterface

interface sbps_out_if;
  import sbps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 record_kind;
  logic [OFF_OUT_W-1:0] match_offset;
  logic                 found_any;
  logic                 last_of_run;

  modport source(output valid, record_kind, match_offset, found_any, last_of_run,
                 input ready);
  modport sink(input valid, record_kind, match_offset, found_any, last_of_run,
               output ready);
endinterface

// File: rtl/sbps_match.sv
// Parallel compare of the current byte and the byte window against the pattern.
// Purely combinational; sits between the input register and the result register.
// Depends on sbps_pkg.
module sbps_match
  import sbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  localparam int unsigned WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1
) (
  input  logic [BYTE_W-1:0]                  cur_i,
  input  logic [WIN_D-1:0][BYTE_W-1:0]       window_i,
  input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern_i,
  input  logic [LEN_W-1:0]                   len_i,
  input  logic [LEN_W-1:0]                   fill_i,
  input  logic                               halted_i,
  output logic                               hit_o
);

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] seq;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] sel;
  logic                               all_eq;
  logic                               fill_ok;

  always_comb begin
    seq[0] = cur_i;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      seq[j] = window_i[j-1];
    end
    // Position j (0 = newest byte) lines up with pattern byte len-1-j.
    for (int j = 0; j < MAX_PATTERN; j++) begin
      sel[j] = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (LEN_W'(k + j + 1) == len_i) begin
          sel[j] = pattern_i[k];
        end
      end
    end
    all_eq = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if ((LEN_W'(j) < len_i) && (sel[j] != seq[j])) begin
        all_eq = 1'b0;
      end
    end
    fill_ok = ({1'b0, fill_i} + (LEN_W+1)'(1)) >= {1'b0, len_i};
    hit_o   = (len_i != '0) && !halted_i && fill_ok && all_eq;
  end

endmodule

// File: rtl/sbps_out.sv
// Result register of the pattern search block: holds the records of one byte
// and presents them on the output channel, match record first.
// Depends on sbps_pkg and sbps_if.
module sbps_out
  import sbps_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sbps_res_t     res_i,
  output logic          can_load_o,
  sbps_out_if.source    out
);

  logic                 has_match_q, has_match_d;
  logic                 has_done_q, has_done_d;
  logic [OFF_OUT_W-1:0] offset_q;
  logic                 found_q;
  logic                 take;

  assign take         = out.valid && out.ready;
  assign out.valid    = has_match_q || has_done_q;
  assign out.record_kind  = has_match_q ? REC_MATCH : REC_DONE;
  assign out.match_offset = has_match_q ? offset_q : '0;
  assign out.found_any    = has_match_q ? 1'b0 : found_q;
  assign out.last_of_run  = has_match_q ? !has_done_q : 1'b1;

  // Free now, or the record being taken is the last one held.
  assign can_load_o = !out.valid || (take && !(has_match_q && has_done_q));

  always_comb begin
    has_match_d = has_match_q;
    has_done_d  = has_done_q;
    if (load_i) begin
      has_match_d = res_i.has_match;
      has_done_d  = res_i.has_done;
    end else if (take) begin
      if (has_match_q) begin
        has_match_d = 1'b0;
      end else begin
        has_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_match_q <= 1'b0;
      has_done_q  <= 1'b0;
    end else begin
      has_match_q <= has_match_d;
      has_done_q  <= has_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      offset_q <= res_i.offset;
      found_q  <= res_i.found;
    end
  end

endmodule

// File: rtl/streaming_byte_pattern_search.sv
// Streaming byte pattern search, top level.
// A file streams in on byte_in, one byte per transaction, with end_of_file set
// on its last byte. Every occurrence of the configured pattern (up to MAX_PATTERN
// bytes), overlapping ones included, gives a match record on rec_out with the
// zero-based offset of its first byte, until a match with the stop register set
// halts the search. The last byte of a file also gives a done record, after any
// match record, telling whether the file held a match; offset, window and flags
// then clear for the next file. Configuration is written through
// cfg_we_i/cfg_index_i/cfg_data_i while idle. Throughput is one byte per cycle
// while the result register can take its records: the byte is registered,
// compared against the window in one pass and its records land in the result
// register. A byte that gives two records holds the result register for two
// output transactions. When rec_out stalls, one more byte is taken into the input
// register; bytes with no records keep flowing past a full result register.
// Reset clears the configuration, the window, the offset counter and the flags.
// Depends on sbps_pkg, sbps_if, sbps_match and sbps_out.
module streaming_byte_pattern_search
  import sbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sbps_in_if.sink               byte_in,
  sbps_out_if.source            rec_out
);

  localparam int unsigned WIN_D = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [CFG_LEN_W-1:0]  pat_len_q;
  logic                  stop_q;

  // Input register.
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_eof_q;

  // Per-file state.
  logic [WIN_D-1:0][BYTE_W-1:0] window_q, window_d;
  logic [OFFSET_BITS-1:0]       seen_q, seen_d;
  logic [LEN_W-1:0]             fill_q, fill_d;
  logic                         found_q, found_d;
  logic                         halted_q, halted_d;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pattern;
  logic [LEN_W-1:0]                   len_raw, len_c;
  logic [OFFSET_BITS-1:0]             start;
  logic                               hit;
  logic                               has_rec;
  logic                               can_load;
  logic                               advance;
  sbps_res_t                          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      stop_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        REG_PAT_HIGH: pat_high_q <= cfg_data_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_data_i[CFG_LEN_W-1:0];
        REG_STOP:     stop_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < REG_BYTES) begin
        pattern[i] = pat_low_q[i*BYTE_W +: BYTE_W];
      end else if (i < 2 * REG_BYTES) begin
        pattern[i] = pat_high_q[(i-REG_BYTES)*BYTE_W +: BYTE_W];
      end else begin
        pattern[i] = '0;
      end
    end
  end

  assign len_raw = LEN_W'(pat_len_q);
  assign len_c   = (len_raw > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_raw;

  sbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .cur_i    (in_byte_q),
    .window_i (window_q),
    .pattern_i(pattern),
    .len_i    (len_c),
    .fill_i   (fill_q),
    .halted_i (halted_q),
    .hit_o    (hit)
  );

  assign start   = seen_q - OFFSET_BITS'(len_c) + OFFSET_BITS'(1);
  assign has_rec = hit || in_eof_q;
  // A byte without records never waits on the result register.
  assign advance = in_valid_q && (can_load || !has_rec);
  assign byte_in.ready = !in_valid_q || advance;

  assign res.has_match = hit;
  assign res.offset    = OFF_OUT_W'(start);
  assign res.has_done  = in_eof_q;
  assign res.found     = found_q || hit;

  sbps_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (advance && has_rec),
    .res_i     (res),
    .can_load_o(can_load),
    .out       (rec_out)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (byte_in.valid && byte_in.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    window_d = window_q;
    seen_d   = seen_q;
    fill_d   = fill_q;
    found_d  = found_q;
    halted_d = halted_q;
    if (advance) begin
      if (in_eof_q) begin
        window_d = '0;
        seen_d   = '0;
        fill_d   = '0;
        found_d  = 1'b0;
        halted_d = 1'b0;
      end else begin
        for (int i = WIN_D - 1; i > 0; i--) begin
          window_d[i] = window_q[i-1];
        end
        window_d[0] = in_byte_q;
        if (fill_q < LEN_W'(MAX_PATTERN - 1)) begin
          fill_d = fill_q + LEN_W'(1);
        end
        if (seen_q != '1) begin
          seen_d = seen_q + OFFSET_BITS'(1);
        end
        found_d  = found_q || hit;
        halted_d = halted_q || (hit && stop_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      window_q   <= '0;
      seen_q     <= '0;
      fill_q     <= '0;
      found_q    <= 1'b0;
      halted_q   <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      window_q   <= window_d;
      seen_q     <= seen_d;
      fill_q     <= fill_d;
      found_q    <= found_d;
      halted_q   <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_in.valid && byte_in.ready) begin
      in_byte_q <= byte_in.data_byte;
      in_eof_q  <= byte_in.end_of_file;
    end
  end

`ifndef NO_ASSERTIONS
  // The last byte of a file leaves the offset counter and fill count at zero.
  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_eof_q) |=> (seen_q == '0 && fill_q == '0 && !halted_q))
    else $error("file state not cleared after end of file");

  // A record that is not the last of its byte can only be a match record.
  a_not_last_is_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_out.valid && !rec_out.last_of_run) |-> (rec_out.record_kind == REC_MATCH))
    else $error("non-final record is not a match");

  // A hit in the middle of a file is remembered for the done record.
  a_hit_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && hit && !in_eof_q) |=> found_q)
    else $error("found flag not set after a hit");

  // Once halted, no further hit is reported in the same file.
  a_halt_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && halted_q) |-> !hit)
    else $error("hit reported while halted");
`endif

endmodule
